// ----- rtl/core/ssm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants of the servo slot manager
// Opcodes, status and drive codes, slot layout, and the constants of the pulse
// and duty arithmetic.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int NUM_PINS     = 40;
	localparam int NUM_CHANNELS = 8;
	localparam int PIN_W        = 6;
	localparam int CHAN_W       = 3;

	localparam int ANGLE_MAX    = 180;
	localparam int MIN_LO       = 500;
	localparam int MIN_HI       = 1500;
	localparam int MAX_LO       = 1500;
	localparam int MAX_HI       = 2500;
	localparam int MIN_DEFAULT  = 1000;
	localparam int MAX_DEFAULT  = 2000;
	localparam int DUTY_MAX     = 8191;

	// floor(x / 180) == (x * RECIP_180) >> SHIFT_180 for x < 2^19
	localparam int RECIP_180    = 745655;
	localparam int SHIFT_180    = 27;
	// floor(y / 20000) == (y * RECIP_20000) >> SHIFT_20000 for y < 2^25
	localparam int RECIP_20000  = 54975582;
	localparam int SHIFT_20000  = 40;

	typedef enum logic [1:0] {
		OP_CONFIG  = 2'd0,
		OP_SET     = 2'd1,
		OP_GET     = 2'd2,
		OP_RELEASE = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_NOT_PERMIT = 3'd1,
		STS_CLAIM_REF  = 3'd2,
		STS_NO_CHANNEL = 3'd3,
		STS_NOT_CONFIG = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		DRV_NONE   = 2'd0,
		DRV_ATTACH = 2'd1,
		DRV_UPDATE = 2'd2,
		DRV_STOP   = 2'd3
	} drive_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_CALC,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [7:0]        angle;
		logic [10:0]       min_us;
		logic [11:0]       max_us;
		logic [CHAN_W-1:0] channel;
	} slot_t;

	typedef struct packed {
		logic             en;
		logic [PIN_W-1:0] addr;
		logic             used;
		slot_t            slot;
	} tbl_wr_t;

	typedef struct packed {
		logic        start;
		logic [7:0]  angle;
		logic [10:0] min_us;
		logic [11:0] diff;
	} calc_req_t;

	typedef struct packed {
		logic        done;
		logic [11:0] pulse;
		logic [12:0] duty;
	} calc_rsp_t;

endpackage

// ----- rtl/core/ssm_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_table: servo slot memory
// One synchronous slot memory with a registered read port, plus one in-use
// flag per pin in flip-flops, cleared by reset.
// ----------------------------------------------------------------------------
module ssm_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [ssm_pkg::PIN_W-1:0] rd_addr,
	output logic                      rd_used,
	output ssm_pkg::slot_t            rd_slot,
	input  ssm_pkg::tbl_wr_t          wr
);

	ssm_pkg::slot_t mem [ssm_pkg::NUM_PINS];
	logic [ssm_pkg::NUM_PINS-1:0] used_q;
	logic rd_used_q;
	ssm_pkg::slot_t rd_slot_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.slot;
		end
		if (rd_en) begin
			rd_slot_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			if (wr.en) begin
				used_q[wr.addr] <= wr.used;
			end
			if (rd_en) begin
				rd_used_q <= used_q[rd_addr];
			end
		end
	end

	assign rd_used = rd_used_q;
	assign rd_slot = rd_slot_q;

endmodule

// ----- rtl/core/ssm_calc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_calc: pulse and duty pipeline
// pulse = min + angle*diff/180, duty = pulse*8191/20000, both truncating.
// Divisions are reciprocal multiplies; at most one multiplier per stage.
// ----------------------------------------------------------------------------
module ssm_calc (
	input  logic                clk,
	input  logic                arst_n,
	input  ssm_pkg::calc_req_t  req,
	output ssm_pkg::calc_rsp_t  rsp
);

	localparam logic [19:0] R180 = 20'(ssm_pkg::RECIP_180);
	localparam logic [25:0] R20K = 26'(ssm_pkg::RECIP_20000);
	localparam logic [12:0] DMAX = 13'(ssm_pkg::DUTY_MAX);

	logic [5:0]  v_q;
	logic [7:0]  angle_s0;
	logic [11:0] diff_s0;
	logic [10:0] min_s0;
	logic [19:0] prod_s1;
	logic [10:0] min_s1;
	logic [39:0] quot_s2;
	logic [10:0] min_s2;
	logic [11:0] pulse_s3;
	logic [24:0] scaled_s4;
	logic [50:0] duty_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[4:0], req.start};
		end
	end

	// hold each stage until the next item passes through
	always_ff @(posedge clk) begin
		if (req.start) begin
			angle_s0 <= req.angle;
			diff_s0  <= req.diff;
			min_s0   <= req.min_us;
		end
		if (v_q[0]) begin
			prod_s1 <= {12'd0, angle_s0} * {8'd0, diff_s0};
			min_s1  <= min_s0;
		end
		if (v_q[1]) begin
			quot_s2 <= {20'd0, prod_s1} * {20'd0, R180};
			min_s2  <= min_s1;
		end
		if (v_q[2]) begin
			pulse_s3 <= {1'b0, min_s2} + quot_s2[ssm_pkg::SHIFT_180 +: 12];
		end
		if (v_q[3]) begin
			scaled_s4 <= {13'd0, pulse_s3} * {12'd0, DMAX};
		end
		if (v_q[4]) begin
			duty_s5 <= {26'd0, scaled_s4} * {25'd0, R20K};
		end
	end

	assign rsp.done  = v_q[5];
	assign rsp.pulse = pulse_s3;
	assign rsp.duty  = duty_s5[ssm_pkg::SHIFT_20000 +: 11] == 11'd0 ? 13'd0
		: {2'b00, duty_s5[ssm_pkg::SHIFT_20000 +: 11]};

endmodule

// ----- rtl/core/servo_slot_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_slot_manager: servo slot table and PWM channel allocator
// Executes configure, set, get and release commands against a per-pin slot
// table and a bitmap of busy PWM channels.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: cmd_valid/cmd_stall with the opcode, pin, angle, pulse
//   limits and the two outside grants. A command beat is taken when cmd_valid
//   is high and cmd_stall is low.
//   Response channel: rsp_valid/rsp_stall with status, angle, pulse, duty,
//   channel, drive action and release_claim; exactly one beat per command.
//   A command passes the slot memory read, the read-modify-write decision, the
//   six-stage pulse/duty multiply chain and the output register; commands are
//   handled one at a time, so a new command is taken only after the last one
//   has left the pipeline.
//   A stalled response is held in the output register; the next command is
//   still taken and its result waits in the pipeline until the output frees.
//   Reset marks every slot unused and every channel free at once; no sweep.
// ----------------------------------------------------------------------------
module servo_slot_manager (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         opcode,
	input  logic [5:0]         pin,
	input  logic signed [15:0] angle_in,
	input  logic signed [15:0] min_pulse_in,
	input  logic signed [15:0] max_pulse_in,
	input  logic               pin_permitted,
	input  logic               claim_granted,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic signed [8:0]  angle_out,
	output logic [11:0]        pulse_out,
	output logic [12:0]        duty_out,
	output logic [2:0]         channel_out,
	output logic [1:0]         drive_action,
	output logic               release_claim
);

	ssm_pkg::state_t state_q, state_d;

	ssm_pkg::opcode_t op_q;
	logic [ssm_pkg::PIN_W-1:0] pin_q;
	logic signed [15:0] angle_q, min_q, max_q;
	logic perm_q, grant_q;
	logic [ssm_pkg::NUM_CHANNELS-1:0] busy_q, busy_d;

	logic rd_en, rd_used;
	ssm_pkg::slot_t rd_slot;
	ssm_pkg::tbl_wr_t wr;
	ssm_pkg::calc_req_t creq;
	ssm_pkg::calc_rsp_t crsp;

	// decision of the lookup cycle
	logic in_range, used, any_free;
	logic [ssm_pkg::CHAN_W-1:0] free_idx;
	logic [7:0]  a_cl;
	logic [10:0] mn_cl, mn_sel;
	logic [11:0] mx_cl, mx_sel;
	ssm_pkg::status_t lk_status;
	logic signed [8:0] lk_angle;
	logic [ssm_pkg::CHAN_W-1:0] lk_chan;
	ssm_pkg::drive_t lk_act;
	logic lk_rel, lk_show;

	ssm_pkg::status_t res_status_q;
	logic signed [8:0] res_angle_q;
	logic [ssm_pkg::CHAN_W-1:0] res_chan_q;
	ssm_pkg::drive_t res_act_q;
	logic res_rel_q, res_show_q;

	logic rsp_load;
	logic rsp_valid_q;
	ssm_pkg::status_t status_q;
	logic signed [8:0] angle_out_q;
	logic [11:0] pulse_q;
	logic [12:0] duty_q;
	logic [ssm_pkg::CHAN_W-1:0] chan_q;
	ssm_pkg::drive_t act_q;
	logic rel_q;

	ssm_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (pin),
		.rd_used (rd_used),
		.rd_slot (rd_slot),
		.wr      (wr)
	);

	ssm_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	// ---------------- command capture ----------------
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			op_q    <= ssm_pkg::opcode_t'(opcode);
			pin_q   <= pin;
			angle_q <= angle_in;
			min_q   <= min_pulse_in;
			max_q   <= max_pulse_in;
			perm_q  <= pin_permitted;
			grant_q <= claim_granted;
		end
	end

	// ---------------- clamps and channel search ----------------
	always_comb begin
		if (angle_q < 0) begin
			a_cl = 8'd0;
		end else if (angle_q > ssm_pkg::ANGLE_MAX) begin
			a_cl = 8'(ssm_pkg::ANGLE_MAX);
		end else begin
			a_cl = angle_q[7:0];
		end
		if (min_q < ssm_pkg::MIN_LO) begin
			mn_cl = 11'(ssm_pkg::MIN_LO);
		end else if (min_q > ssm_pkg::MIN_HI) begin
			mn_cl = 11'(ssm_pkg::MIN_HI);
		end else begin
			mn_cl = min_q[10:0];
		end
		if (max_q < ssm_pkg::MAX_LO) begin
			mx_cl = 12'(ssm_pkg::MAX_LO);
		end else if (max_q > ssm_pkg::MAX_HI) begin
			mx_cl = 12'(ssm_pkg::MAX_HI);
		end else begin
			mx_cl = max_q[11:0];
		end
		// lowest free channel wins
		any_free = 1'b0;
		free_idx = '0;
		for (int i = ssm_pkg::NUM_CHANNELS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				any_free = 1'b1;
				free_idx = ssm_pkg::CHAN_W'(i);
			end
		end
	end

	// ---------------- read-modify-write decision ----------------
	always_comb begin
		in_range  = int'(pin_q) < ssm_pkg::NUM_PINS;
		used      = in_range && rd_used;
		lk_status = ssm_pkg::STS_OK;
		lk_angle  = used ? $signed({1'b0, rd_slot.angle}) : -9'sd1;
		lk_chan   = '0;
		lk_act    = ssm_pkg::DRV_NONE;
		lk_rel    = 1'b0;
		lk_show   = 1'b0;
		busy_d    = busy_q;
		mn_sel    = rd_slot.min_us;
		mx_sel    = rd_slot.max_us;
		creq.angle = rd_slot.angle;
		wr.en     = 1'b0;
		wr.addr   = pin_q;
		wr.used   = 1'b1;
		wr.slot   = rd_slot;

		case (op_q)
			ssm_pkg::OP_CONFIG: begin
				if ({1'b0, mn_cl} >= mx_cl) begin
					mn_sel = 11'(ssm_pkg::MIN_DEFAULT);
					mx_sel = 12'(ssm_pkg::MAX_DEFAULT);
				end else begin
					mn_sel = mn_cl;
					mx_sel = mx_cl;
				end
				creq.angle = a_cl;
				if (!in_range || !perm_q) begin
					lk_status = ssm_pkg::STS_NOT_PERMIT;
				end else if (!grant_q) begin
					lk_status = ssm_pkg::STS_CLAIM_REF;
				end else if (!used && !any_free) begin
					lk_status = ssm_pkg::STS_NO_CHANNEL;
					lk_rel    = 1'b1;
				end else begin
					lk_chan   = used ? rd_slot.channel : free_idx;
					lk_act    = ssm_pkg::DRV_ATTACH;
					lk_angle  = $signed({1'b0, a_cl});
					lk_show   = 1'b1;
					busy_d[lk_chan] = 1'b1;
					wr.en          = 1'b1;
					wr.slot.angle  = a_cl;
					wr.slot.min_us = mn_sel;
					wr.slot.max_us = mx_sel;
					wr.slot.channel = lk_chan;
				end
			end
			ssm_pkg::OP_SET: begin
				creq.angle = a_cl;
				if (!used) begin
					lk_status = ssm_pkg::STS_NOT_CONFIG;
				end else begin
					lk_chan  = rd_slot.channel;
					lk_act   = ssm_pkg::DRV_UPDATE;
					lk_angle = $signed({1'b0, a_cl});
					lk_show  = 1'b1;
					wr.en         = 1'b1;
					wr.slot.angle = a_cl;
				end
			end
			ssm_pkg::OP_GET: begin
				if (!used) begin
					lk_status = ssm_pkg::STS_NOT_CONFIG;
				end else begin
					lk_chan = rd_slot.channel;
					lk_show = 1'b1;
				end
			end
			ssm_pkg::OP_RELEASE: begin
				if (used) begin
					lk_chan  = rd_slot.channel;
					lk_act   = ssm_pkg::DRV_STOP;
					lk_rel   = 1'b1;
					lk_angle = -9'sd1;
					busy_d[rd_slot.channel] = 1'b0;
					wr.en   = 1'b1;
					wr.used = 1'b0;
					wr.slot = '0;
				end
			end
			default: begin
				lk_status = ssm_pkg::STS_OK;
			end
		endcase

		wr.en       = wr.en && (state_q == ssm_pkg::S_LOOK);
		creq.min_us = mn_sel;
		creq.diff   = mx_sel - {1'b0, mn_sel};
		creq.start  = (state_q == ssm_pkg::S_LOOK);
	end

	always_ff @(posedge clk) begin
		if (state_q == ssm_pkg::S_LOOK) begin
			res_status_q <= lk_status;
			res_angle_q  <= lk_angle;
			res_chan_q   <= lk_chan;
			res_act_q    <= lk_act;
			res_rel_q    <= lk_rel;
			res_show_q   <= lk_show;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssm_pkg::S_IDLE;
			busy_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ssm_pkg::S_LOOK) begin
				busy_q <= busy_d;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		rd_en     = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ssm_pkg::S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					rd_en   = int'(pin) < ssm_pkg::NUM_PINS;
					state_d = ssm_pkg::S_LOOK;
				end
			end
			ssm_pkg::S_LOOK: begin
				state_d = ssm_pkg::S_CALC;
			end
			ssm_pkg::S_CALC: begin
				if (crsp.done) begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_load = 1'b1;
						state_d  = ssm_pkg::S_IDLE;
					end else begin
						state_d = ssm_pkg::S_OUT;
					end
				end
			end
			ssm_pkg::S_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ssm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ssm_pkg::S_IDLE;
			end
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status_q    <= res_status_q;
			angle_out_q <= res_angle_q;
			pulse_q     <= res_show_q ? crsp.pulse : 12'd0;
			duty_q      <= res_show_q ? crsp.duty : 13'd0;
			chan_q      <= res_chan_q;
			act_q       <= res_act_q;
			rel_q       <= res_rel_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign angle_out     = angle_out_q;
	assign pulse_out     = pulse_q;
	assign duty_out      = duty_q;
	assign channel_out   = chan_q;
	assign drive_action  = act_q;
	assign release_claim = rel_q;

	// ---------------- assertions ----------------
	a_accept_looks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q == ssm_pkg::S_LOOK))
		else $error("command beat not followed by table lookup");

	a_rsp_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == ssm_pkg::S_CALC
			|| $past(state_q) == ssm_pkg::S_OUT))
		else $error("response raised outside the result states");

	a_stop_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && drive_action == ssm_pkg::DRV_STOP) |-> release_claim)
		else $error("stop without claim release");

	a_attach_busy: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(rsp_valid) && drive_action == ssm_pkg::DRV_ATTACH)
			|-> busy_q[channel_out])
		else $error("attached channel not marked busy");

endmodule
